// File: rtl/rrr_pkg.sv
// Shared types and constants of the ray reflect / refract pipeline.
`default_nettype none
package rrr_pkg;

  localparam int DATA_W   = 16;
  localparam int ETA_W    = 15;
  localparam int DOT_W    = 34;
  localparam int COS_W    = 35;
  localparam int PERP_W   = 24;
  localparam int LEN_W    = 50;
  localparam int ROOT_W   = 25;
  localparam int TRIAL_W  = 52;
  localparam int WIDE_W   = 52;
  localparam int SHI_W    = 26;
  localparam int EPROD_W  = 41;
  localparam int ES_W     = 67;
  localparam int RN_W     = 42;

  localparam logic OP_REFLECT = 1'b0;
  localparam logic OP_REFRACT = 1'b1;

  // Everything one item carries down the pipeline; unused fields trim away.
  typedef struct packed {
    logic                          op;
    logic [2:0][DATA_W-1:0]        d;
    logic [2:0][DATA_W-1:0]        n;
    logic [ETA_W-1:0]              eta;
    logic [2:0][2*DATA_W-1:0]      prod;
    logic [DOT_W-1:0]              dot;
    logic [COS_W-1:0]              cosv;
    logic [2:0][DOT_W+DATA_W-1:0]  m_dn;
    logic [2:0][COS_W+DATA_W-1:0]  m_cn;
    logic [2:0][WIDE_W-1:0]        rv;
    logic [2:0][WIDE_W-1:0]        s;
    logic [2:0][EPROD_W-1:0]       eh;
    logic [2:0][EPROD_W-1:0]       el;
    logic [2:0][DATA_W-1:0]        rres;
    logic [2:0][ES_W-1:0]          es;
    logic [2:0][PERP_W-1:0]        perp;
    logic [2:0][2*PERP_W-1:0]      sq;
    logic [LEN_W-1:0]              len;
    logic [LEN_W-1:0]              rem;
    logic [ROOT_W-1:0]             root;
    logic [2:0][RN_W-1:0]          rn;
    logic [2:0][DATA_W-1:0]        res;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/rrr_if.sv
// Request and result channel interfaces of the ray reflect / refract core.
`default_nettype none
interface rrr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] dir_x;
  logic [15:0] dir_y;
  logic [15:0] dir_z;
  logic [15:0] norm_x;
  logic [15:0] norm_y;
  logic [15:0] norm_z;
  logic [14:0] eta_ratio;
  modport source (output valid, opcode, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                  eta_ratio, input ready);
  modport sink (input valid, opcode, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z,
                eta_ratio, output ready);
endinterface

interface rrr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [15:0] out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface
`default_nettype wire

// File: rtl/rrr_sqrt_step.sv
// One digit of the pipelined integer square root.
`default_nettype none
module rrr_sqrt_step #(
  parameter int BIT = 0
) (
  input  rrr_pkg::item_t in_item,
  output rrr_pkg::item_t out_item
);
  import rrr_pkg::*;

  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] rem_ext;

  always_comb begin
    out_item = in_item;
    trial    = (TRIAL_W'(in_item.root) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
    rem_ext  = TRIAL_W'(in_item.rem);
    if (rem_ext >= trial) begin
      out_item.rem  = LEN_W'(rem_ext - trial);
      out_item.root = in_item.root | (ROOT_W'(1) << BIT);
    end
  end
endmodule
`default_nettype wire

// File: rtl/ray_reflect_refract_core.sv
// Top level of the ray reflect / refract core.
//
// Usage: one request on in_req carries opcode, dir_x/y/z, norm_x/y/z and
// eta_ratio (Q3.12); one result on out_res carries out_x/y/z (Q3.12,
// saturated). Opcode reflect gives d - 2(d.n)n; refract gives Snell's vector
// form with |1 - |perp|^2| under the root.
// Throughput: one request per cycle while out_res is not held.
// Depth: 39 register stages, set by the 25-stage square root, one root
// bit per stage, plus the stages before and after it.
// Reset: synchronous, active low; clears every stage valid bit, so the
// pipeline comes up empty. Payload registers are not reset.
// Stall: all stages advance together while the output stage is empty or
// taken; while out_res is held, in_req.ready drops and every stage holds,
// so nothing is lost or repeated.
`default_nettype none
module ray_reflect_refract_core (
  input wire logic clk,
  input wire logic rst_n,
  rrr_in_if.sink   in_req,
  rrr_out_if.source out_res
);
  import rrr_pkg::*;

  localparam int SQ_FIRST = 12;
  localparam int NST      = SQ_FIRST + ROOT_W + 2;
  localparam int ST_RN    = NST - 2;
  localparam int ST_OUT   = NST - 1;
  localparam logic [COS_W-1:0] ONE_COS = COS_W'(1) << 24;
  localparam logic [LEN_W-1:0] ONE_LEN = LEN_W'(1) << 24;

  item_t            st_r   [NST];
  item_t            st_nxt [NST];
  logic [NST-1:0]   vld_r;
  logic             adv;

  // Saturate to 16 bits; the caller rounds first.
  function automatic logic [DATA_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(32767)) begin
      return 16'h7FFF;
    end else if (v < -WIDE_W'(32768)) begin
      return 16'h8000;
    end
    return v[DATA_W-1:0];
  endfunction

  // Advance whenever the output register is free or being taken.
  assign adv          = !vld_r[ST_OUT] || out_res.ready;
  assign in_req.ready = adv;

  // Capture the request.
  always_comb begin
    st_nxt[0]      = st_r[0];
    st_nxt[0].op   = in_req.opcode;
    st_nxt[0].d    = {in_req.dir_z, in_req.dir_y, in_req.dir_x};
    st_nxt[0].n    = {in_req.norm_z, in_req.norm_y, in_req.norm_x};
    st_nxt[0].eta  = in_req.eta_ratio;
  end

  // Component products of d.n.
  always_comb begin
    st_nxt[1] = st_r[0];
    for (int i = 0; i < 3; i++) begin
      st_nxt[1].prod[i] = 32'(32'($signed(st_r[0].d[i])) * 32'($signed(st_r[0].n[i])));
    end
  end

  // Sum into the dot product.
  always_comb begin
    st_nxt[2]     = st_r[1];
    st_nxt[2].dot = DOT_W'($signed(st_r[1].prod[0])) + DOT_W'($signed(st_r[1].prod[1]))
                  + DOT_W'($signed(st_r[1].prod[2]));
  end

  // Clamp cos = min(-dot, 1).
  always_comb begin
    logic signed [COS_W-1:0] ndot;
    ndot      = -COS_W'($signed(st_r[2].dot));
    st_nxt[3] = st_r[2];
    st_nxt[3].cosv = (ndot > $signed(ONE_COS)) ? ONE_COS : ndot;
  end

  // dot * n for reflect, cos * n for refract.
  always_comb begin
    st_nxt[4] = st_r[3];
    for (int i = 0; i < 3; i++) begin
      st_nxt[4].m_dn[i] = 50'(50'($signed(st_r[3].dot)) * 50'($signed(st_r[3].n[i])));
      st_nxt[4].m_cn[i] = 51'(51'($signed(st_r[3].cosv)) * 51'($signed(st_r[3].n[i])));
    end
  end

  // Reflect numerator and refract sum d + cos*n, both Q.36.
  always_comb begin
    st_nxt[5] = st_r[4];
    for (int i = 0; i < 3; i++) begin
      st_nxt[5].rv[i] = (WIDE_W'($signed(st_r[4].d[i])) <<< 24)
                      - (WIDE_W'($signed(st_r[4].m_dn[i])) <<< 1);
      st_nxt[5].s[i]  = (WIDE_W'($signed(st_r[4].d[i])) <<< 24)
                      + WIDE_W'($signed(st_r[4].m_cn[i]));
    end
  end

  // Split eta * s into two partial products; finish the reflect result.
  always_comb begin
    logic signed [WIDE_W-1:0] rr;
    st_nxt[6] = st_r[5];
    rr        = '0;
    for (int i = 0; i < 3; i++) begin
      st_nxt[6].eh[i] = EPROD_W'($signed(EPROD_W'($signed(st_r[5].s[i][WIDE_W-1:SHI_W])))
                        * $signed(EPROD_W'(st_r[5].eta)));
      st_nxt[6].el[i] = EPROD_W'(EPROD_W'(st_r[5].eta) * EPROD_W'(st_r[5].s[i][SHI_W-1:0]));
      rr = ($signed(st_r[5].rv[i]) + (WIDE_W'(1) <<< 23)) >>> 24;
      st_nxt[6].rres[i] = sat16(rr);
    end
  end

  // Recombine eta * s in Q.48.
  always_comb begin
    st_nxt[7] = st_r[6];
    for (int i = 0; i < 3; i++) begin
      st_nxt[7].es[i] = (ES_W'($signed(st_r[6].eh[i])) <<< SHI_W)
                      + ES_W'($signed({1'b0, st_r[6].el[i]}));
    end
  end

  // Round to Q.12 and saturate perp to 24 bits.
  always_comb begin
    logic signed [ES_W-1:0] t;
    st_nxt[8] = st_r[7];
    t         = '0;
    for (int i = 0; i < 3; i++) begin
      t = ($signed(st_r[7].es[i]) + (ES_W'(1) <<< 35)) >>> 36;
      if (t > ES_W'(24'sh7FFFFF)) begin
        st_nxt[8].perp[i] = 24'h7FFFFF;
      end else if (t < -(ES_W'(1) <<< 23)) begin
        st_nxt[8].perp[i] = 24'h800000;
      end else begin
        st_nxt[8].perp[i] = t[PERP_W-1:0];
      end
    end
  end

  // Square each perp component.
  always_comb begin
    st_nxt[9] = st_r[8];
    for (int i = 0; i < 3; i++) begin
      st_nxt[9].sq[i] = 48'(48'($signed(st_r[8].perp[i])) * 48'($signed(st_r[8].perp[i])));
    end
  end

  // |perp|^2.
  always_comb begin
    st_nxt[10]     = st_r[9];
    st_nxt[10].len = LEN_W'(st_r[9].sq[0]) + LEN_W'(st_r[9].sq[1]) + LEN_W'(st_r[9].sq[2]);
  end

  // |1 - |perp|^2| seeds the root.
  always_comb begin
    st_nxt[11]      = st_r[10];
    st_nxt[11].rem  = (st_r[10].len >= ONE_LEN) ? st_r[10].len - ONE_LEN
                                                : ONE_LEN - st_r[10].len;
    st_nxt[11].root = '0;
  end

  // Square root, most significant bit first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rrr_sqrt_step #(.BIT(ROOT_W - 1 - k)) u_step (
      .in_item  (st_r[SQ_FIRST - 1 + k]),
      .out_item (st_nxt[SQ_FIRST + k])
    );
  end

  // root * n.
  always_comb begin
    st_nxt[ST_RN] = st_r[ST_RN-1];
    for (int i = 0; i < 3; i++) begin
      st_nxt[ST_RN].rn[i] = RN_W'($signed(RN_W'($signed({1'b0, st_r[ST_RN-1].root})))
                            * $signed(RN_W'($signed(st_r[ST_RN-1].n[i]))));
    end
  end

  // Final refract rounding, or pass the reflect result.
  always_comb begin
    logic signed [WIDE_W-1:0] v;
    st_nxt[ST_OUT] = st_r[ST_RN];
    v              = '0;
    for (int i = 0; i < 3; i++) begin
      v = ((WIDE_W'($signed(st_r[ST_RN].perp[i])) <<< 12)
          - WIDE_W'($signed(st_r[ST_RN].rn[i])) + (WIDE_W'(1) <<< 11)) >>> 12;
      st_nxt[ST_OUT].res[i] = (st_r[ST_RN].op == OP_REFRACT) ? sat16(v)
                                                            : st_r[ST_RN].rres[i];
    end
  end

  // Valid bits travel with the data; hold everything on a stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  assign out_res.valid = vld_r[ST_OUT];
  assign out_res.out_x = st_r[ST_OUT].res[0];
  assign out_res.out_y = st_r[ST_OUT].res[1];
  assign out_res.out_z = st_r[ST_OUT].res[2];
endmodule
`default_nettype wire

// File: rtl/rrr_checker.sv
// Port-level assertions of the ray reflect / refract core, with its bind.
`default_nettype none
module rrr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_x,
  input wire logic [15:0] out_y,
  input wire logic [15:0] out_z
);
  // Pipeline accepts exactly when the output stage frees.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not track output stage");

  // A stall must back up into the request side.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("request taken during stall");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_x) && $stable(out_y) && $stable(out_z)))
    else $error("result changed while stalled");
endmodule

bind ray_reflect_refract_core rrr_checker u_rrr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_req.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .out_x     (out_res.out_x),
  .out_y     (out_res.out_y),
  .out_z     (out_res.out_z)
);
`default_nettype wire
